### sv/dfe_pkg.sv
`timescale 1ns / 1ps

package dfe_pkg;

   localparam int FRAME_SLOTS_DEFAULT = 18;
   localparam int DATA_SLOTS          = 16;
   localparam int VALUE_W             = 11;
   localparam int WORD_W              = 12;
   localparam int NIBBLE_W            = 4;
   localparam int COUNT_W             = 16;
   localparam int CSR_INDEX_W         = 1;

   localparam logic [COUNT_W-1:0] ZERO_COUNT_RESET = 16'd62;
   localparam logic [COUNT_W-1:0] ONE_COUNT_RESET  = 16'd124;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ZERO_COUNT = 1'b0,
      CSR_ONE_COUNT  = 1'b1
   } csr_index_type;

   typedef logic [DATA_SLOTS-1:0] frame_type;

   // one encoded frame handed between front, queue and back
   typedef struct packed {
      logic      valid;
      frame_type frame;
   } frame_xfer_type;

   typedef struct packed {
      logic [COUNT_W-1:0] zero_count;
      logic [COUNT_W-1:0] one_count;
   } slot_cfg_type;

   // word = value:telemetry, checksum = xor of its three nibbles
   function automatic frame_type frame_build(logic [VALUE_W-1:0] value, logic telem);
      logic [WORD_W-1:0]   word;
      logic [NIBBLE_W-1:0] csum;
      word = {value, telem};
      csum = word[11:8] ^ word[7:4] ^ word[3:0];
      return {word, csum};
   endfunction

endpackage

### sv/dfe_if.sv
`timescale 1ns / 1ps

interface dfe_req_if;
   logic                         valid;
   logic                         ready;
   logic [dfe_pkg::VALUE_W-1:0]  throttle_value;
   logic                         telemetry_request;

   modport source (output valid, output throttle_value, output telemetry_request,
                   input ready);
   modport sink   (input valid, input throttle_value, input telemetry_request,
                   output ready);
endinterface

interface dfe_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dfe_pkg::COUNT_W-1:0]  slot_compare;
   logic                         last_slot;

   modport source (output valid, output slot_compare, output last_slot, input ready);
   modport sink   (input valid, input slot_compare, input last_slot, output ready);
endinterface

### sv/dshot_frame_encoder.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload                                  Transaction
// req      in   throttle_value[10:0], telemetry_request  one DSHOT frame
// rsp      out  slot_compare[15:0], last_slot            one bit slot
// csr      in   csr_index[0], csr_write_data[15:0]       register write
//
// Each req transaction yields FRAME_SLOTS rsp transactions, one per cycle
// when rsp is ready; the slot serializer in dfe_back sets that rate.
// Frames follow each other with no idle cycle; a two-entry queue between
// the encoder front and the serializer keeps req open while slots drain.
// Reset (synchronous) empties the queue and restores the slot counts.
// An rsp stall holds the output register and, once the queue fills, req.
module dshot_frame_encoder #(
   parameter int FRAME_SLOTS = dfe_pkg::FRAME_SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   dfe_req_if.sink                           req,
   dfe_rsp_if.source                         rsp,
   input  logic                              csr_write_enable,
   input  logic [dfe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dfe_pkg::COUNT_W-1:0]       csr_write_data
);
   import dfe_pkg::*;

   slot_cfg_type   cfg_ff, cfg_in;
   frame_xfer_type push, head;
   logic           queue_full;
   logic           pop;

   // slot counts; the user must write them only while idle, which the block itself does not enforce
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_ZERO_COUNT: cfg_in.zero_count = csr_write_data;
            CSR_ONE_COUNT:  cfg_in.one_count  = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_count <= ZERO_COUNT_RESET;
         cfg_ff.one_count  <= ONE_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dfe_front u_front (
      .req        (req),
      .queue_full (queue_full),
      .push       (push)
   );

   dfe_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   dfe_back #(
      .FRAME_SLOTS (FRAME_SLOTS)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .cfg   (cfg_ff),
      .rsp   (rsp)
   );

   // trailing slots carry no high time
   a_last_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.last_slot |-> rsp.slot_compare == '0)
      else $error("last slot carries a nonzero compare");

   // a frame, once started, is emitted without a bubble
   a_frame_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && !rsp.last_slot |=> rsp.valid)
      else $error("gap inside a frame");

   // output register comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("rsp valid right after reset");

endmodule

### sv/dfe_front.sv
`timescale 1ns / 1ps

module dfe_front (
   dfe_req_if.sink                 req,
   input  logic                    queue_full,
   output dfe_pkg::frame_xfer_type push
);
   import dfe_pkg::*;

   // accept whenever the queue has room; encode in flight
   assign req.ready  = ~queue_full;
   assign push.valid = req.valid & ~queue_full;
   assign push.frame = frame_build(req.throttle_value, req.telemetry_request);

endmodule

### sv/dfe_queue.sv
`timescale 1ns / 1ps

module dfe_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  dfe_pkg::frame_xfer_type push,
   output logic                    full,
   output dfe_pkg::frame_xfer_type head,
   input  logic                    pop
);
   import dfe_pkg::*;

   // two-entry frame queue
   frame_type  entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head.valid = (count_ff != 2'd0);
   assign head.frame = entries_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push.valid & ~full;
      do_pop    = pop & head.valid;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.frame;
      end
   end

endmodule

### sv/dfe_back.sv
`timescale 1ns / 1ps

module dfe_back #(
   parameter int FRAME_SLOTS = dfe_pkg::FRAME_SLOTS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dfe_pkg::frame_xfer_type head,
   output logic                    pop,
   input  dfe_pkg::slot_cfg_type   cfg,
   dfe_rsp_if.source               rsp
);
   import dfe_pkg::*;

   localparam int SLOT_W = $clog2(FRAME_SLOTS);

   logic                busy_ff, busy_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   frame_type           frame_ff, frame_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  compare_ff, compare_in;
   logic                last_ff, last_in;
   logic                advance, last_now, load;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.slot_compare = compare_ff;
   assign rsp.last_slot    = last_ff;
   assign pop              = load;

   always_comb begin
      advance  = ~rsp_valid_ff | rsp.ready;
      last_now = busy_ff & (slot_ff == SLOT_W'(FRAME_SLOTS - 1));
      // next frame loads on the edge that emits the last slot: no gap
      load     = advance & head.valid & (~busy_ff | last_now);

      busy_in      = busy_ff;
      slot_in      = slot_ff;
      frame_in     = frame_ff;
      rsp_valid_in = rsp_valid_ff;
      compare_in   = compare_ff;
      last_in      = last_ff;

      if (advance) begin
         rsp_valid_in = busy_ff;
         last_in      = last_now;
         if (slot_ff < SLOT_W'(DATA_SLOTS)) begin
            compare_in = frame_ff[DATA_SLOTS-1] ? cfg.one_count : cfg.zero_count;
         end else begin
            compare_in = '0;
         end
         if (busy_ff) begin
            frame_in = {frame_ff[DATA_SLOTS-2:0], 1'b0};
            slot_in  = slot_ff + SLOT_W'(1);
            if (last_now) begin
               busy_in = 1'b0;
            end
         end
         if (load) begin
            frame_in = head.frame;
            slot_in  = '0;
            busy_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff   <= frame_in;
      compare_ff <= compare_in;
      last_ff    <= last_in;
   end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

// DSHOT frame encoder bench.
// One req transaction carries an 11-bit throttle/command value and the
// telemetry request bit. The block answers with FRAME_SLOTS rsp
// transactions: 16 bit-slot compare counts, MSB first, then zero slots,
// and last_slot marks the final one.
module testbench;
   import dfe_pkg::*;

   localparam int NUM_SLOTS      = FRAME_SLOTS_DEFAULT;
   localparam int NUM_DIRECTED   = 15;
   localparam int NUM_PHASES     = 7;
   localparam int ITEMS_PER_PASS = 70;
   localparam int PRESSURE_ITEMS = 12;
   localparam int LONG_HOLD      = 400;   // receiver hold-off, in cycles
   localparam int IDLE_LIMIT     = 4000;  // cycles with no transaction at all
   localparam int DRAIN_CYCLES   = 40;    // quiet time after the last slot

   // One directed row. When frame_known is set the frame was worked out
   // by hand and the predictor is not consulted for that row.
   typedef struct packed {
      logic [VALUE_W-1:0]    value;
      logic                  telem;
      logic                  frame_known;
      logic [DATA_SLOTS-1:0] frame;
   } dshot_case_type;

   // One expected bit slot
   typedef struct packed {
      logic [COUNT_W-1:0] slot_compare;
      logic               last_slot;
   } slot_word_type;

   logic clock;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COUNT_W-1:0]     csr_write_data;

   dfe_req_if req_bus ();
   dfe_rsp_if rsp_bus ();

   // Local copy of the two count registers
   logic [COUNT_W-1:0] zero_count_cfg;
   logic [COUNT_W-1:0] one_count_cfg;

   slot_word_type pending_slots[$];
   int            error_count;
   int            idle_cycles;
   bit            gaps_on;
   bit            hold_off_request;

   // Directed stimulus: ends of the value range, the command band
   // (1..47 must pass through unclamped), first throttle value,
   // alternating bit patterns and both telemetry settings.
   dshot_case_type directed_cases [0:NUM_DIRECTED-1] = '{
      '{11'd0,    1'b0, 1'b1, 16'h0000},  // stop, all zero bits
      '{11'd2047, 1'b1, 1'b1, 16'hFFFF},  // all one bits
      '{11'd0,    1'b1, 1'b1, 16'h0011},  // telemetry bit alone
      '{11'd2047, 1'b0, 1'b1, 16'hFFEE},
      '{11'd1024, 1'b0, 1'b1, 16'h8008},  // top value bit alone
      '{11'd1,    1'b0, 1'b0, 16'h0000},  // lowest command
      '{11'd1,    1'b1, 1'b0, 16'h0000},
      '{11'd5,    1'b0, 1'b0, 16'h0000},
      '{11'd21,   1'b1, 1'b0, 16'h0000},
      '{11'd47,   1'b0, 1'b0, 16'h0000},  // highest command
      '{11'd47,   1'b1, 1'b0, 16'h0000},
      '{11'd48,   1'b0, 1'b0, 16'h0000},  // lowest throttle
      '{11'd1023, 1'b1, 1'b0, 16'h0000},
      '{11'd1365, 1'b0, 1'b0, 16'h0000},  // 101 0101 0101
      '{11'd682,  1'b1, 1'b0, 16'h0000}   // 010 1010 1010
   };

   // Slot counts per random pass; the last two passes draw theirs
   logic [COUNT_W-1:0] pass_zero_counts [0:NUM_PHASES-1] = '{
      16'd0, 16'd65535, 16'd1000, 16'd0, 16'd65535, 16'd0, 16'd0
   };
   logic [COUNT_W-1:0] pass_one_counts [0:NUM_PHASES-1] = '{
      16'd65535, 16'd0, 16'd1000, 16'd0, 16'd65535, 16'd0, 16'd0
   };

   dshot_frame_encoder #(
      .FRAME_SLOTS (NUM_SLOTS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Frame = {value, telemetry, checksum}; checksum is the xor of the
   // three nibbles of the 12-bit word.
   function automatic logic [DATA_SLOTS-1:0] dshot_frame_bits(
      logic [VALUE_W-1:0] value, logic telem);
      logic [WORD_W-1:0]   word;
      logic [NIBBLE_W-1:0] crc;
      int                  n;
      word = {value, telem};
      crc  = '0;
      for (n = 0; n < 3; n++)
         crc = crc ^ word[n*NIBBLE_W +: NIBBLE_W];
      return {word, crc};
   endfunction

   // Expand one frame into its slot compare counts, MSB first
   function automatic void queue_frame_slots(logic [DATA_SLOTS-1:0] frame);
      slot_word_type s;
      int            slot;
      for (slot = 0; slot < NUM_SLOTS; slot++) begin
         if (slot < DATA_SLOTS)
            s.slot_compare = frame[DATA_SLOTS-1-slot] ? one_count_cfg : zero_count_cfg;
         else
            s.slot_compare = '0;
         s.last_slot = (slot == NUM_SLOTS - 1);
         pending_slots.push_back(s);
      end
   endfunction

   // Mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(4, 40);
   endfunction

   // Present one throttle transaction at the falling edge and hold it
   // until it is taken. Slots are predicted at the accepting edge.
   task automatic offer_throttle(logic [VALUE_W-1:0] value, logic telem,
                                 logic frame_known, logic [DATA_SLOTS-1:0] frame);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.valid             = 1'b1;
      req_bus.throttle_value    = value;
      req_bus.telemetry_request = telem;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      queue_frame_slots(frame_known ? frame : dshot_frame_bits(value, telem));
   endtask

   // Random throttle: command band and range ends get extra weight
   task automatic offer_random_throttle();
      logic [VALUE_W-1:0] value;
      int                 r;
      r = $urandom_range(0, 9);
      if (r < 2)
         value = VALUE_W'($urandom_range(1, 47));
      else if (r == 2) begin
         case ($urandom_range(0, 4))
            0: value = 11'd0;
            1: value = 11'd1;
            2: value = 11'd47;
            3: value = 11'd48;
            default: value = 11'd2047;
         endcase
      end else
         value = VALUE_W'($urandom_range(0, 2047));
      offer_throttle(value, 1'($urandom_range(0, 1)), 1'b0, '0);
   endtask

   // Drop valid, then wait until every predicted slot has come out
   task automatic drain_frames();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_slots.size() != 0)
         @(posedge clock);
   endtask

   // Both count registers, written back to back while the block is idle
   task automatic write_slot_counts(logic [COUNT_W-1:0] zero_count,
                                    logic [COUNT_W-1:0] one_count);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = CSR_ZERO_COUNT;
      csr_write_data   = zero_count;
      @(negedge clock);
      csr_index        = CSR_ONE_COUNT;
      csr_write_data   = one_count;
      @(negedge clock);
      csr_write_enable = 1'b0;
      zero_count_cfg   = zero_count;
      one_count_cfg    = one_count;
   endtask

   // Receiver: random stalls, or one long hold-off when asked, so that
   // the frame queue fills and req backs up.
   initial begin
      int stall_left;
      int n;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_bus.ready = 1'b0;
            for (n = 1; n < LONG_HOLD; n++)
               @(negedge clock);
            hold_off_request = 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (gaps_on && $urandom_range(0, 3) == 0)
               stall_left = pick_gap();
         end
      end
   end

   // Slot checker: every rsp transaction against the oldest prediction
   always @(posedge clock) begin
      slot_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_slots.size() == 0) begin
            error_count++;
            $display("%0t unexpected slot: got compare %0d last %0b",
                     $time, rsp_bus.slot_compare, rsp_bus.last_slot);
         end else begin
            want = pending_slots.pop_front();
            if (rsp_bus.slot_compare !== want.slot_compare) begin
               error_count++;
               $display("%0t slot_compare mismatch: expected %0d, actual %0d",
                        $time, want.slot_compare, rsp_bus.slot_compare);
            end
            if (rsp_bus.last_slot !== want.last_slot) begin
               error_count++;
               $display("%0t last_slot mismatch: expected %0b, actual %0b",
                        $time, want.last_slot, rsp_bus.last_slot);
            end
         end
      end
   end

   // Watchdog: stuck when no transaction moves on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t timeout: %0d slots still expected", $time, pending_slots.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Main sequence
   initial begin
      int i;
      int p;
      error_count               = 0;
      idle_cycles               = 0;
      gaps_on                   = 1'b1;
      hold_off_request          = 1'b0;
      reset                     = 1'b1;
      csr_write_enable          = 1'b0;
      csr_index                 = CSR_ZERO_COUNT;
      csr_write_data            = '0;
      req_bus.valid             = 1'b0;
      req_bus.throttle_value    = '0;
      req_bus.telemetry_request = 1'b0;
      zero_count_cfg            = 16'd62;   // reset values
      one_count_cfg             = 16'd124;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed rows run on the reset counts
      for (i = 0; i < NUM_DIRECTED; i++)
         offer_throttle(directed_cases[i].value, directed_cases[i].telem,
                        directed_cases[i].frame_known, directed_cases[i].frame);
      drain_frames();

      // Random passes, each under its own count setting: extremes, swapped
      // extremes, equal counts, both zero, both full scale, then random
      for (p = 0; p < NUM_PHASES; p++) begin
         if (p >= NUM_PHASES - 2)
            write_slot_counts(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
         else
            write_slot_counts(pass_zero_counts[p], pass_one_counts[p]);
         gaps_on = (p != 2);   // one pass runs back to back on both sides
         if (p == 1) begin
            // Long receiver hold-off while req keeps offering
            hold_off_request = 1'b1;
            gaps_on          = 1'b0;
            for (i = 0; i < PRESSURE_ITEMS; i++)
               offer_random_throttle();
            gaps_on = 1'b1;
         end
         for (i = 0; i < ITEMS_PER_PASS; i++)
            offer_random_throttle();
         drain_frames();
      end

      // Catch any stray slot after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
